// ===== rtl/tccs_pkg.sv =====
`default_nettype none
package tccs_pkg;

	localparam int CONSOLES     = 4;
	localparam int COLUMNS      = 80;
	localparam int SCREEN_CELLS = 2000;

	localparam int CONS_W   = 2;
	localparam int CHAR_W   = 8;
	localparam int ATTR_W   = 8;
	localparam int ADDR_W   = 14;
	localparam int REGION_W = 15;
	localparam int CIDX_W   = (CONSOLES > 1) ? $clog2(CONSOLES) : 1;
	// exact cell position: enough for CONSOLES * max region
	localparam int CELL_W   = REGION_W + CIDX_W;
	localparam int SUM_W    = CELL_W + 1;
	localparam int COL_W    = $clog2(COLUMNS);

	localparam int DATA_W   = 32;
	localparam int PADDR_W  = 3;
	localparam int REGIDX_W = 1;

	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	localparam logic [REGION_W-1:0] REGION_RESET = REGION_W'(4080);
	localparam logic [ATTR_W-1:0]   ATTR_RESET   = ATTR_W'(7);

	localparam logic [CHAR_W-1:0] CH_NEWLINE   = CHAR_W'(10);
	localparam logic [CHAR_W-1:0] CH_BACKSPACE = CHAR_W'(8);
	localparam logic [CHAR_W-1:0] CH_SPACE     = CHAR_W'(32);

	localparam logic [REGIDX_W-1:0] REG_REGION = REGIDX_W'(0);
	localparam logic [REGIDX_W-1:0] REG_ATTR   = REGIDX_W'(1);

	typedef enum logic [1:0] {
		MODE_PUT    = 2'd0,
		MODE_UP     = 2'd1,
		MODE_DOWN   = 2'd2,
		MODE_SELECT = 2'd3
	} mode_t;

	typedef enum logic [2:0] {
		OP_NOP,
		OP_PRINT,
		OP_NEWLINE,
		OP_BACKSPACE,
		OP_UP,
		OP_DOWN,
		OP_SELECT
	} op_t;

	typedef struct packed {
		op_t                op;
		logic [CONS_W-1:0]  console;
		logic [CHAR_W-1:0]  ch;
	} req_t;

	typedef struct packed {
		logic                rebase;
		logic [REGION_W-1:0] region;
		logic [ATTR_W-1:0]   attr;
	} cfg_t;

	function automatic logic [CELL_W-1:0] base_of(input int k,
			input logic [REGION_W-1:0] region);
		return CELL_W'(k) * CELL_W'(region);
	endfunction

endpackage
`default_nettype wire

// ===== rtl/tccs_front.sv =====
`default_nettype none
module tccs_front (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         req_valid,
	output logic                              req_stall,
	input  wire logic [1:0]                   mode,
	input  wire logic [tccs_pkg::CONS_W-1:0]  console,
	input  wire logic [tccs_pkg::CHAR_W-1:0]  char_code,
	input  wire logic                         full,
	output logic                              push,
	output tccs_pkg::req_t                    push_req
);

	logic           valid_s1;
	tccs_pkg::req_t req_s1;
	tccs_pkg::req_t cls;
	logic           accept;

	assign req_stall = valid_s1 && full;
	assign accept    = req_valid && !req_stall;
	assign push      = valid_s1 && !full;
	assign push_req  = req_s1;

	// classify the request into one back-end operation
	always_comb begin
		cls.console = console;
		cls.ch      = char_code;
		case (tccs_pkg::mode_t'(mode))
			tccs_pkg::MODE_PUT: begin
				if (char_code == tccs_pkg::CH_NEWLINE)
					cls.op = tccs_pkg::OP_NEWLINE;
				else if (char_code == tccs_pkg::CH_BACKSPACE)
					cls.op = tccs_pkg::OP_BACKSPACE;
				else
					cls.op = tccs_pkg::OP_PRINT;
			end
			tccs_pkg::MODE_UP:     cls.op = tccs_pkg::OP_UP;
			tccs_pkg::MODE_DOWN:   cls.op = tccs_pkg::OP_DOWN;
			tccs_pkg::MODE_SELECT: cls.op = tccs_pkg::OP_SELECT;
			default:               cls.op = tccs_pkg::OP_NOP;
		endcase
		if (32'(console) >= tccs_pkg::CONSOLES)
			cls.op = tccs_pkg::OP_NOP;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (push) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_s1 <= cls;
		end
	end

endmodule
`default_nettype wire

// ===== rtl/tccs_queue.sv =====
`default_nettype none
module tccs_queue (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            push,
	input  wire tccs_pkg::req_t  push_req,
	output logic                 full,
	input  wire logic            pop,
	output logic                 empty,
	output tccs_pkg::req_t       pop_req
);

	tccs_pkg::req_t                      entry_q [tccs_pkg::QUEUE_DEPTH];
	logic [tccs_pkg::QPTR_W-1:0]         wr_ptr_q;
	logic [tccs_pkg::QPTR_W-1:0]         rd_ptr_q;
	logic [tccs_pkg::QCNT_W-1:0]         count_q;
	logic                                do_push;
	logic                                do_pop;

	localparam logic [tccs_pkg::QPTR_W-1:0] LAST = tccs_pkg::QPTR_W'(tccs_pkg::QUEUE_DEPTH - 1);
	localparam logic [tccs_pkg::QCNT_W-1:0] FULL_CNT = tccs_pkg::QCNT_W'(tccs_pkg::QUEUE_DEPTH);

	assign full    = (count_q == FULL_CNT);
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign pop_req = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= (wr_ptr_q == LAST) ? '0 : wr_ptr_q + 1'b1;
			if (do_pop)
				rd_ptr_q <= (rd_ptr_q == LAST) ? '0 : rd_ptr_q + 1'b1;
			if (do_push && !do_pop)
				count_q <= count_q + 1'b1;
			else if (do_pop && !do_push)
				count_q <= count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (do_push)
			entry_q[wr_ptr_q] <= push_req;
	end

endmodule
`default_nettype wire

// ===== rtl/tccs_back.sv =====
`default_nettype none
module tccs_back (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire tccs_pkg::cfg_t               cfg,
	input  wire logic                         empty,
	input  wire tccs_pkg::req_t               pop_req,
	output logic                              pop,
	output logic                              rsp_valid,
	input  wire logic                         rsp_stall,
	output logic                              mem_write,
	output logic [tccs_pkg::ADDR_W-1:0]       mem_addr,
	output logic [tccs_pkg::CHAR_W-1:0]       mem_char,
	output logic [tccs_pkg::ATTR_W-1:0]       mem_attr,
	output logic                              crtc_update,
	output logic [tccs_pkg::ADDR_W-1:0]       cursor_pos,
	output logic [tccs_pkg::ADDR_W-1:0]       view_start
);

	localparam int CW = tccs_pkg::CELL_W;
	localparam int SW = tccs_pkg::SUM_W;
	localparam int NC = tccs_pkg::CONSOLES;
	localparam logic [SW-1:0] COLS_S   = SW'(tccs_pkg::COLUMNS);
	localparam logic [SW-1:0] SCREEN_S = SW'(tccs_pkg::SCREEN_CELLS);
	localparam logic [tccs_pkg::COL_W-1:0] COL_LAST = tccs_pkg::COL_W'(tccs_pkg::COLUMNS - 1);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EXEC,
		ST_SCROLL,
		ST_EMIT
	} state_t;

	state_t                            state_q;
	tccs_pkg::req_t                    req_q;
	logic [CW-1:0]                     cursor_q [NC];
	logic [CW-1:0]                     view_q   [NC];
	logic [CW-1:0]                     base_q   [NC];
	logic [SW-1:0]                     limit_q  [NC];
	logic [tccs_pkg::COL_W-1:0]        col_q    [NC];
	logic [tccs_pkg::CIDX_W-1:0]       active_q;
	logic                              wr_q;
	logic [tccs_pkg::ADDR_W-1:0]       addr_q;
	logic [tccs_pkg::CHAR_W-1:0]       char_q;
	logic                              rsp_valid_q;
	logic                              mem_write_q;
	logic [tccs_pkg::ADDR_W-1:0]       mem_addr_q;
	logic [tccs_pkg::CHAR_W-1:0]       mem_char_q;
	logic [tccs_pkg::ATTR_W-1:0]       mem_attr_q;
	logic [tccs_pkg::ATTR_W-1:0]       attr_q;
	logic                              crtc_q;
	logic [tccs_pkg::ADDR_W-1:0]       cursor_pos_q;
	logic [tccs_pkg::ADDR_W-1:0]       view_start_q;

	logic [tccs_pkg::CIDX_W-1:0]       k;
	logic [CW-1:0]                     cur;
	logic [CW-1:0]                     view;
	logic [tccs_pkg::COL_W-1:0]        col;
	logic [SW-1:0]                     view_end;
	logic                              can_down;
	logic                              need_scroll;
	logic                              out_free;

	assign k           = req_q.console[tccs_pkg::CIDX_W-1:0];
	assign cur         = cursor_q[k];
	assign view        = view_q[k];
	assign col         = col_q[k];
	assign view_end    = SW'(view) + SCREEN_S;
	assign can_down    = view_end < limit_q[k];
	assign need_scroll = SW'(cur) >= view_end;
	assign out_free    = !rsp_valid_q || !rsp_stall;
	assign pop         = (state_q == ST_IDLE) && !empty;

	assign rsp_valid   = rsp_valid_q;
	assign mem_write   = mem_write_q;
	assign mem_addr    = mem_addr_q;
	assign mem_char    = mem_char_q;
	assign mem_attr    = mem_attr_q;
	assign crtc_update = crtc_q;
	assign cursor_pos  = cursor_pos_q;
	assign view_start  = view_start_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			active_q    <= '0;
			rsp_valid_q <= 1'b0;
			wr_q        <= 1'b0;
			for (int i = 0; i < NC; i++) begin
				cursor_q[i] <= tccs_pkg::base_of(i, tccs_pkg::REGION_RESET);
				view_q[i]   <= tccs_pkg::base_of(i, tccs_pkg::REGION_RESET);
				base_q[i]   <= tccs_pkg::base_of(i, tccs_pkg::REGION_RESET);
				limit_q[i]  <= SW'(tccs_pkg::base_of(i + 1, tccs_pkg::REGION_RESET));
				col_q[i]    <= '0;
			end
		end else begin
			// result taken; a new one from the emit state replaces it instead
			if (rsp_valid_q && !rsp_stall && (state_q != ST_EMIT))
				rsp_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (!empty) begin
						req_q   <= pop_req;
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					wr_q    <= 1'b0;
					addr_q  <= '0;
					char_q  <= '0;
					attr_q  <= cfg.attr;
					state_q <= ST_EMIT;
					case (req_q.op)
						tccs_pkg::OP_PRINT: begin
							if (SW'(cur) + SW'(1) < limit_q[k]) begin
								wr_q        <= 1'b1;
								addr_q      <= cur[tccs_pkg::ADDR_W-1:0];
								char_q      <= req_q.ch;
								cursor_q[k] <= cur + 1'b1;
								col_q[k]    <= (col == COL_LAST) ? '0 : col + 1'b1;
							end
							state_q <= ST_SCROLL;
						end
						tccs_pkg::OP_NEWLINE: begin
							if (SW'(cur) + COLS_S < limit_q[k]) begin
								cursor_q[k] <= CW'(SW'(cur) + COLS_S - SW'(col));
								col_q[k]    <= '0;
							end
							state_q <= ST_SCROLL;
						end
						tccs_pkg::OP_BACKSPACE: begin
							if (cur > base_q[k]) begin
								wr_q        <= 1'b1;
								addr_q      <= tccs_pkg::ADDR_W'(cur - 1'b1);
								char_q      <= tccs_pkg::CH_SPACE;
								cursor_q[k] <= cur - 1'b1;
								col_q[k]    <= (col == '0) ? COL_LAST : col - 1'b1;
							end
							state_q <= ST_SCROLL;
						end
						tccs_pkg::OP_UP: begin
							if (view > base_q[k])
								view_q[k] <= CW'(SW'(view) - COLS_S);
						end
						tccs_pkg::OP_DOWN: begin
							if (can_down)
								view_q[k] <= CW'(SW'(view) + COLS_S);
						end
						tccs_pkg::OP_SELECT: begin
							active_q <= k;
						end
						default: begin
						end
					endcase
				end
				ST_SCROLL: begin
					// one row per cycle until the cursor falls inside the view or the view reaches the region end
					if (need_scroll && can_down)
						view_q[k] <= CW'(SW'(view) + COLS_S);
					else
						state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (out_free) begin
						rsp_valid_q  <= 1'b1;
						mem_write_q  <= wr_q;
						mem_addr_q   <= addr_q;
						mem_char_q   <= char_q;
						mem_attr_q   <= wr_q ? attr_q : '0;
						if ((req_q.op != tccs_pkg::OP_NOP) && (active_q == k)) begin
							crtc_q       <= 1'b1;
							cursor_pos_q <= cur[tccs_pkg::ADDR_W-1:0];
							view_start_q <= view[tccs_pkg::ADDR_W-1:0];
						end else begin
							crtc_q       <= 1'b0;
							cursor_pos_q <= '0;
							view_start_q <= '0;
						end
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
			// region change: every console back to the start of its region
			if (cfg.rebase) begin
				for (int i = 0; i < NC; i++) begin
					cursor_q[i] <= tccs_pkg::base_of(i, cfg.region);
					view_q[i]   <= tccs_pkg::base_of(i, cfg.region);
					base_q[i]   <= tccs_pkg::base_of(i, cfg.region);
					limit_q[i]  <= SW'(tccs_pkg::base_of(i + 1, cfg.region));
					col_q[i]    <= '0;
				end
			end
		end
	end

endmodule
`default_nettype wire

// ===== rtl/text_console_cursor_scroll.sv =====
// path: front register, queue, then the back end's idle, exec and emit states into the result register;
//   characters pass a scroll state between exec and emit that moves the view toward the cursor
// occupancy: the back end holds one request from idle until emit hands it on, and emit waits on rsp_stall;
//   it takes no new request before that, and the view scroll loop moves one row per cycle
// reset: arst_n clears the control state at once; cursors and views start at their region
//   base (region 4080 cells), attribute 7, console 0 active; no clearing pass
`default_nettype none
module text_console_cursor_scroll (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	// request channel
	input  wire logic                          req_valid,
	output logic                               req_stall,
	input  wire logic [1:0]                    mode,
	input  wire logic [tccs_pkg::CONS_W-1:0]   console,
	input  wire logic [tccs_pkg::CHAR_W-1:0]   char_code,
	// result channel
	output logic                               rsp_valid,
	input  wire logic                          rsp_stall,
	output logic                               mem_write,
	output logic [tccs_pkg::ADDR_W-1:0]        mem_addr,
	output logic [tccs_pkg::CHAR_W-1:0]        mem_char,
	output logic [tccs_pkg::ATTR_W-1:0]        mem_attr,
	output logic                               crtc_update,
	output logic [tccs_pkg::ADDR_W-1:0]        cursor_pos,
	output logic [tccs_pkg::ADDR_W-1:0]        view_start,
	// configuration port
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [tccs_pkg::PADDR_W-1:0]  paddr,
	input  wire logic [tccs_pkg::DATA_W-1:0]   pwdata,
	output logic [tccs_pkg::DATA_W-1:0]        prdata,
	output logic                               pready
);

	logic [tccs_pkg::REGION_W-1:0]  region_q;
	logic [tccs_pkg::ATTR_W-1:0]    attr_q;
	logic [tccs_pkg::REGIDX_W-1:0]  reg_idx;
	logic                           wr_en;
	tccs_pkg::cfg_t                 cfg;

	logic                           push;
	tccs_pkg::req_t                 push_req;
	logic                           full;
	logic                           pop;
	logic                           empty;
	tccs_pkg::req_t                 pop_req;

	// register map: word 0 region size, word 1 character attribute
	assign pready  = 1'b1;
	assign reg_idx = paddr[2 +: tccs_pkg::REGIDX_W];
	assign wr_en   = psel && penable && pwrite && pready;

	always_comb begin
		case (reg_idx)
			tccs_pkg::REG_REGION: prdata = tccs_pkg::DATA_W'(region_q);
			tccs_pkg::REG_ATTR:   prdata = tccs_pkg::DATA_W'(attr_q);
			default:              prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			region_q <= tccs_pkg::REGION_RESET;
			attr_q   <= tccs_pkg::ATTR_RESET;
		end else if (wr_en) begin
			if (reg_idx == tccs_pkg::REG_REGION)
				region_q <= pwdata[tccs_pkg::REGION_W-1:0];
			if (reg_idx == tccs_pkg::REG_ATTR)
				attr_q <= pwdata[tccs_pkg::ATTR_W-1:0];
		end
	end

	// a region write rebases the console state in the same edge
	assign cfg.rebase = wr_en && (reg_idx == tccs_pkg::REG_REGION);
	assign cfg.region = pwdata[tccs_pkg::REGION_W-1:0];
	assign cfg.attr   = attr_q;

	// front: takes a request, decodes mode and character into an operation
	tccs_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.mode      (mode),
		.console   (console),
		.char_code (char_code),
		.full      (full),
		.push      (push),
		.push_req  (push_req)
	);

	// short queue decouples decode from execution
	tccs_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_req (push_req),
		.full     (full),
		.pop      (pop),
		.empty    (empty),
		.pop_req  (pop_req)
	);

	// back: per-console cursor and view state, scroll loop, result register
	tccs_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg),
		.empty       (empty),
		.pop_req     (pop_req),
		.pop         (pop),
		.rsp_valid   (rsp_valid),
		.rsp_stall   (rsp_stall),
		.mem_write   (mem_write),
		.mem_addr    (mem_addr),
		.mem_char    (mem_char),
		.mem_attr    (mem_attr),
		.crtc_update (crtc_update),
		.cursor_pos  (cursor_pos),
		.view_start  (view_start)
	);

endmodule
`default_nettype wire

// ===== rtl/tccs_checker.sv =====
`default_nettype none
module tccs_checker (
	input wire logic                          clk,
	input wire logic                          arst_n,
	input wire logic                          rsp_valid,
	input wire logic                          rsp_stall,
	input wire logic                          mem_write,
	input wire logic [tccs_pkg::ADDR_W-1:0]   mem_addr,
	input wire logic [tccs_pkg::CHAR_W-1:0]   mem_char,
	input wire logic [tccs_pkg::ATTR_W-1:0]   mem_attr,
	input wire logic                          crtc_update,
	input wire logic [tccs_pkg::ADDR_W-1:0]   cursor_pos,
	input wire logic [tccs_pkg::ADDR_W-1:0]   view_start,
	input wire logic                          pready
);

	// a stalled result holds
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(mem_addr) && $stable(cursor_pos)
			&& $stable(view_start) && $stable(mem_char))
		else $error("stalled result changed");

	// no cell write means the memory fields read zero
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !mem_write |-> mem_addr == '0 && mem_char == '0 && mem_attr == '0)
		else $error("memory fields set without a write");

	// inactive console reports nothing to the crtc
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !crtc_update |-> cursor_pos == '0 && view_start == '0)
		else $error("crtc fields set without update");

	// config port never waits
	assert property (@(posedge clk) disable iff (!arst_n) pready)
		else $error("pready dropped");

endmodule

bind text_console_cursor_scroll tccs_checker u_tccs_checker (.*);
`default_nettype wire

// ===== test/tb.sv =====
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import tccs_pkg::*;

	// first this many failures are printed in full, later ones only counted
	localparam int MAX_REPORTS   = 10;
	// margin for the longest character path, which scrolls the view one row at a time
	localparam int SETTLE_CYCLES = 260;

	// one result as the block presents it
	typedef struct packed {
		logic              wr;
		logic [ADDR_W-1:0] addr;
		logic [CHAR_W-1:0] ch;
		logic [ATTR_W-1:0] attr;
		logic              upd;
		logic [ADDR_W-1:0] cursor;
		logic [ADDR_W-1:0] view;
	} console_result_t;

	// clock, reset and every block input start at a known value
	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic              req_valid = 1'b0;
	logic              req_stall;
	logic [1:0]        mode = MODE_PUT;
	logic [CONS_W-1:0] console = '0;
	logic [CHAR_W-1:0] char_code = '0;

	logic              rsp_valid;
	logic              rsp_stall = 1'b0;
	logic              mem_write;
	logic [ADDR_W-1:0] mem_addr;
	logic [CHAR_W-1:0] mem_char;
	logic [ATTR_W-1:0] mem_attr;
	logic              crtc_update;
	logic [ADDR_W-1:0] cursor_pos;
	logic [ADDR_W-1:0] view_start;

	logic               psel = 1'b0;
	logic               penable = 1'b0;
	logic               pwrite = 1'b0;
	logic [PADDR_W-1:0] paddr = '0;
	logic [DATA_W-1:0]  pwdata = '0;
	logic [DATA_W-1:0]  prdata;
	logic               pready;

	text_console_cursor_scroll dut (.*);

	always #6 clk = ~clk;

	// shadow copy of the console engine: registers, cursors, views, active console
	int unsigned region_cells;
	int unsigned char_attr;
	int unsigned cursor_cell [CONSOLES];
	int unsigned view_cell [CONSOLES];
	int unsigned active_console;

	// results still owed by the block, oldest first
	console_result_t pending_results[$];

	// bookkeeping
	int error_count;
	int requests_sent;
	int cells_written;
	int view_moves;
	int settings_used;
	bit idle_enable = 1'b1;
	int stall_left;

	// every cursor and view back to the base of its own region
	function automatic void rebase_consoles();
		for (int k = 0; k < CONSOLES; k++) begin
			cursor_cell[k] = k * region_cells;
			view_cell[k] = k * region_cells;
		end
	endfunction

	// applies one request to the shadow state and returns what the block must report
	function automatic console_result_t advance_console(input logic [1:0] m,
			input logic [CONS_W-1:0] con, input logic [CHAR_W-1:0] ch);
		console_result_t r;
		int unsigned k, base, limit, cur;
		r = '0;
		k = con;
		if (k >= CONSOLES)
			return r;
		base = k * region_cells;
		limit = base + region_cells;
		case (m)
			MODE_SELECT: active_console = k;
			MODE_UP: begin
				if (view_cell[k] > base) begin
					view_cell[k] -= COLUMNS;
					view_moves++;
				end
			end
			MODE_DOWN: begin
				if (view_cell[k] + SCREEN_CELLS < limit) begin
					view_cell[k] += COLUMNS;
					view_moves++;
				end
			end
			default: begin
				cur = cursor_cell[k];
				if (ch == CH_NEWLINE) begin
					// start of next row, unless that row lies past the region
					if (cur + COLUMNS < limit)
						cur = base + COLUMNS * ((cur - base) / COLUMNS + 1);
				end else if (ch == CH_BACKSPACE) begin
					// blank the previous cell, never below the region base
					if (cur > base) begin
						cur--;
						r.wr = 1'b1;
						r.addr = ADDR_W'(cur);
						r.ch = CH_SPACE;
						r.attr = ATTR_W'(char_attr);
					end
				end else if (cur + 1 < limit) begin
					// the last cell of a region is never written
					r.wr = 1'b1;
					r.addr = ADDR_W'(cur);
					r.ch = ch;
					r.attr = ATTR_W'(char_attr);
					cur++;
				end
				cursor_cell[k] = cur;
				// follow the cursor down one row at a time, stopping at region end
				while (cursor_cell[k] >= view_cell[k] + SCREEN_CELLS &&
						view_cell[k] + SCREEN_CELLS < limit) begin
					view_cell[k] += COLUMNS;
					view_moves++;
				end
			end
		endcase
		if (r.wr)
			cells_written++;
		// only the active console drives the crtc; positions wrap to 14 bits
		if (k == active_console) begin
			r.upd = 1'b1;
			r.cursor = ADDR_W'(cursor_cell[k]);
			r.view = ADDR_W'(view_cell[k]);
		end
		return r;
	endfunction

	function automatic void report_error(input string msg);
		error_count++;
		if (error_count <= MAX_REPORTS)
			$display("error at %0t: %s", $realtime, msg);
	endfunction

	function automatic void check_field(input string name, input logic [DATA_W-1:0] got,
			input logic [DATA_W-1:0] want);
		if (got !== want)
			report_error($sformatf("%s expected %0d, got %0d", name, want, got));
	endfunction

	function automatic logic [CHAR_W-1:0] random_glyph();
		logic [CHAR_W-1:0] c;
		c = CHAR_W'($urandom_range(0, 255));
		while (c == CH_NEWLINE || c == CH_BACKSPACE)
			c = CHAR_W'($urandom_range(0, 255));
		return c;
	endfunction

	// result side: random stall bursts, changed on the falling edge
	always @(negedge clk) begin
		if (stall_left == 0 && idle_enable && $urandom_range(0, 5) == 0)
			stall_left = $urandom_range(1, 11);
		if (stall_left != 0) begin
			rsp_stall <= 1'b1;
			stall_left--;
		end else begin
			rsp_stall <= 1'b0;
		end
	end

	// result checker: each accepted result against the oldest expectation
	always @(posedge clk) begin : result_check
		console_result_t want;
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (pending_results.size() == 0) begin
				report_error("result with no request outstanding");
			end else begin
				want = pending_results.pop_front();
				check_field("mem_write", mem_write, want.wr);
				check_field("mem_addr", mem_addr, want.addr);
				check_field("mem_char", mem_char, want.ch);
				check_field("mem_attr", mem_attr, want.attr);
				check_field("crtc_update", crtc_update, want.upd);
				check_field("cursor_pos", cursor_pos, want.cursor);
				check_field("view_start", view_start, want.view);
			end
		end
	end

	// one request; entered and left on a falling edge
	task automatic send_request(input logic [1:0] m, input logic [CONS_W-1:0] con,
			input logic [CHAR_W-1:0] ch);
		if (idle_enable && $urandom_range(0, 4) == 0) begin
			req_valid <= 1'b0;
			repeat ($urandom_range(1, 11)) @(negedge clk);
		end
		req_valid <= 1'b1;
		mode <= m;
		console <= con;
		char_code <= ch;
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
		pending_results.push_back(advance_console(m, con, ch));
		requests_sent++;
		@(negedge clk);
	endtask

	// stop sending and hold off until the block has answered everything
	task automatic wait_for_results();
		req_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(negedge clk);
	endtask

	task automatic write_register(input logic [REGIDX_W-1:0] idx,
			input logic [DATA_W-1:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		// shadow registers follow the write
		if (idx == REG_REGION) begin
			region_cells = value[REGION_W-1:0];
			rebase_consoles();
		end else if (idx == REG_ATTR) begin
			char_attr = value[ATTR_W-1:0];
		end
	endtask

	task automatic read_register(input logic [REGIDX_W-1:0] idx,
			input logic [DATA_W-1:0] want);
		logic [DATA_W-1:0] got;
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= {idx, 2'b00};
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		got = prdata;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		check_field(idx == REG_REGION ? "region_cells read" : "char_attribute read",
			got, want);
	endtask

	// random traffic built from typing-like sequences with some noise mixed in
	task automatic run_console_traffic(input int n_requests);
		int stop_at;
		int kind;
		logic [CONS_W-1:0] focus;
		stop_at = requests_sent + n_requests;
		focus = CONS_W'($urandom_range(0, 3));
		while (requests_sent < stop_at) begin
			if ($urandom_range(0, 7) == 0)
				focus = CONS_W'($urandom_range(0, 3));
			kind = $urandom_range(0, 15);
			case (kind)
				0, 1, 2, 3, 4: begin
					// a line of text, sometimes ended by a newline
					repeat ($urandom_range(1, 40))
						send_request(MODE_PUT, focus, random_glyph());
					if ($urandom_range(0, 1) == 1)
						send_request(MODE_PUT, focus, CH_NEWLINE);
				end
				5, 6: begin
					// runs of newlines push the cursor toward the region end
					repeat ($urandom_range(1, 30))
						send_request(MODE_PUT, focus, CH_NEWLINE);
				end
				7: begin
					// look back, then type: the view has to chase the cursor
					repeat ($urandom_range(1, 12))
						send_request(MODE_UP, focus, CHAR_W'($urandom));
					send_request(MODE_PUT, focus, random_glyph());
				end
				8: begin
					repeat ($urandom_range(1, 6))
						send_request(MODE_DOWN, focus, CHAR_W'($urandom));
				end
				9: begin
					repeat ($urandom_range(1, 12))
						send_request(MODE_PUT, focus, CH_BACKSPACE);
				end
				10, 11: send_request(MODE_SELECT, focus, CHAR_W'($urandom));
				12: begin
					// now and then let the pipeline run dry before going on
					if ($urandom_range(0, 3) == 0)
						wait_for_results();
				end
				default: begin
					repeat ($urandom_range(1, 3))
						send_request(2'($urandom), CONS_W'($urandom), CHAR_W'($urandom));
				end
			endcase
		end
	endtask

	// reset values of both registers as seen on the config port
	task automatic test_register_reset();
		read_register(REG_REGION, DATA_W'(REGION_RESET));
		read_register(REG_ATTR, DATA_W'(ATTR_RESET));
	endtask

	// selecting each console reports its untouched cursor and view at the base
	task automatic test_console_select();
		send_request(MODE_SELECT, 2'd3, 8'h00);
		send_request(MODE_SELECT, 2'd2, 8'hff);
		send_request(MODE_SELECT, 2'd1, 8'h55);
		send_request(MODE_SELECT, 2'd0, 8'haa);
	endtask

	// backspace at the base, extreme printable codes, newline and backspace
	task automatic test_character_handling();
		send_request(MODE_PUT, 2'd0, CH_BACKSPACE);
		send_request(MODE_PUT, 2'd0, 8'h00);
		send_request(MODE_PUT, 2'd0, 8'hff);
		send_request(MODE_PUT, 2'd0, 8'h41);
		send_request(MODE_PUT, 2'd0, CH_BACKSPACE);
		send_request(MODE_PUT, 2'd0, CH_NEWLINE);
		send_request(MODE_PUT, 2'd0, CH_NEWLINE);
		send_request(MODE_PUT, 2'd0, 8'h09);
	endtask

	// scroll up at the base does nothing, scroll down moves a row
	task automatic test_view_scrolling();
		send_request(MODE_UP, 2'd0, 8'h00);
		send_request(MODE_DOWN, 2'd0, 8'h00);
		send_request(MODE_DOWN, 2'd0, 8'hff);
		send_request(MODE_UP, 2'd0, 8'h00);
	endtask

	// requests on inactive consoles update state but not the crtc
	task automatic test_inactive_console();
		send_request(MODE_PUT, 2'd2, 8'h7e);
		send_request(MODE_PUT, 2'd3, CH_NEWLINE);
		send_request(MODE_DOWN, 2'd1, 8'h00);
		send_request(MODE_PUT, 2'd2, CH_BACKSPACE);
		wait_for_results();
	endtask

	// new region size rebases every console; then random traffic on it
	task automatic test_region_setting(input int unsigned region, input int unsigned attr,
			input int n_requests);
		wait_for_results();
		write_register(REG_REGION, {17'($urandom), REGION_W'(region)});
		write_register(REG_ATTR, {24'($urandom), ATTR_W'(attr)});
		read_register(REG_REGION, DATA_W'(region));
		read_register(REG_ATTR, DATA_W'(attr));
		settings_used++;
		run_console_traffic(n_requests);
	endtask

	// attribute change alone must leave cursors and views where they are
	task automatic test_attribute_only(input int unsigned attr, input int n_requests);
		wait_for_results();
		write_register(REG_ATTR, {24'($urandom), ATTR_W'(attr)});
		read_register(REG_ATTR, DATA_W'(attr));
		settings_used++;
		run_console_traffic(n_requests);
	endtask

	initial begin
		region_cells = REGION_RESET;
		char_attr = ATTR_RESET;
		active_console = 0;
		rebase_consoles();
		settings_used = 1;

		repeat (2) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_register_reset();
		test_console_select();
		test_character_handling();
		test_view_scrolling();
		test_inactive_console();

		// smallest region: the view cannot scroll, region end comes fast
		test_region_setting(2000, 8'hff, 100);
		// region of 16384 cells: upper consoles' positions wrap past 14 bits
		test_region_setting(16384, 8'h00, 90);
		// five spare rows, so the view scrolls and still hits the end
		test_region_setting(2400, $urandom_range(0, 255), 90);
		test_attribute_only($urandom_range(0, 255), 50);
		// back to the reset size with both sides running flat out
		idle_enable = 1'b0;
		test_region_setting(REGION_RESET, ATTR_RESET, 110);

		wait_for_results();
		repeat (SETTLE_CYCLES) @(negedge clk);
		if (pending_results.size() != 0)
			report_error($sformatf("%0d results never arrived", pending_results.size()));

		$display("%0d requests over %0d register settings: %0d cells written, %0d view moves",
			requests_sent, settings_used, cells_written, view_moves);
		$display("%0d failures found", error_count);
		if (error_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

	// hard stop in case the block hangs
	initial begin
		#5ms;
		$display("timeout: %0d results still outstanding", pending_results.size());
		$display("Some tests failed");
		$finish;
	end

endmodule
